[design/srlp_pkg.sv]
// Shared constants and types for the sensor record line parser.
// No dependencies.
package srlp_pkg;

    localparam int LINE_LIMIT_DEF = 256;
    localparam int NUM_COLS       = 6;
    localparam int TOK_DEPTH      = 2;
    localparam int RES_DEPTH      = 2;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int TEMP_W  = 8;
    localparam int ACC_W   = 16;
    localparam int VAL_W   = 17;

    localparam logic [YEAR_W-1:0] YEAR_MIN_RST = 14'd1900;
    localparam logic [YEAR_W-1:0] YEAR_MAX_RST = 14'd2100;
    localparam logic [TEMP_W-1:0] TEMP_MIN_RST = 8'h9D;
    localparam logic [TEMP_W-1:0] TEMP_MAX_RST = 8'd99;

    localparam int MONTH_LO = 1;
    localparam int MONTH_HI = 12;
    localparam int DAY_LO   = 1;
    localparam int DAY_HI   = 31;
    localparam int HOUR_LO  = 0;
    localparam int HOUR_HI  = 23;
    localparam int MIN_LO   = 0;
    localparam int MIN_HI   = 59;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [2:0] CLS_SPACE = 3'd0;
    localparam logic [2:0] CLS_PLUS  = 3'd1;
    localparam logic [2:0] CLS_MINUS = 3'd2;
    localparam logic [2:0] CLS_DIGIT = 3'd3;
    localparam logic [2:0] CLS_SEMI  = 3'd4;
    localparam logic [2:0] CLS_OTHER = 3'd5;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_LONG = 3'd7;

    localparam logic [1:0] REG_YEAR_MIN = 2'd0;
    localparam logic [1:0] REG_YEAR_MAX = 2'd1;
    localparam logic [1:0] REG_TEMP_MIN = 2'd2;
    localparam logic [1:0] REG_TEMP_MAX = 2'd3;

    typedef struct packed {
        logic       is_end;
        logic       too_long;
        logic [2:0] cls;
        logic [3:0] digit;
    } tok_t;

    typedef struct packed {
        logic [2:0]         error_code;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [TEMP_W-1:0]  temperature;
    } result_t;

endpackage

[design/sensor_record_line_parser.sv]
// Sensor record line parser, top level: front end, token queue, back end,
// result queue. Depends on srlp_pkg, srlp_fifo, srlp_front, srlp_back.
//
// Input channel: push/full with ch and line_end; one byte per item, an
// item with line_end high closes the line. Result channel: empty/pop with
// error_code and the six parsed fields; one result per line.
// Config: cfg_we/cfg_index/cfg_data, no read-back;
// 0 year_min, 1 year_max, 2 temp_min, 3 temp_max.
// Throughput: one item per cycle while full is low. The front end classifies
// and counts each byte and queues a token; the back end scans one token per
// cycle (held at a line end while the result queue is full) with a single
// multiply-by-ten accumulator step. With no backlog, the line_end token is
// registered in the token queue and the line's result in the result queue.
// Reset clears line state and loads the default bounds; both queues empty.
// When the receiver stalls, the result queue fills, then the back end holds
// at the next line end, the token queue fills and full rises.
module sensor_record_line_parser #(
    parameter int LINE_LIMIT = srlp_pkg::LINE_LIMIT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          ch,
    input  logic                                line_end,
    output logic                                empty,
    input  logic                                pop,
    output logic [2:0]                          error_code,
    output logic [srlp_pkg::YEAR_W-1:0]         year,
    output logic [srlp_pkg::MONTH_W-1:0]        month,
    output logic [srlp_pkg::DAY_W-1:0]          day,
    output logic [srlp_pkg::HOUR_W-1:0]         hour,
    output logic [srlp_pkg::MIN_W-1:0]          minute,
    output logic signed [srlp_pkg::TEMP_W-1:0]  temperature,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [srlp_pkg::YEAR_W-1:0]         cfg_data
);

    srlp_pkg::tok_t    tok_in, tok_out;
    srlp_pkg::result_t res_in, res_out;
    logic              tok_push, tok_full, tok_empty, tok_pop;
    logic              res_push, res_full;

    srlp_front #(
        .LINE_LIMIT(LINE_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (push && !full),
        .ch       (ch),
        .line_end (line_end),
        .tok_push (tok_push),
        .tok      (tok_in)
    );

    srlp_fifo #(
        .WIDTH($bits(srlp_pkg::tok_t)),
        .DEPTH(srlp_pkg::TOK_DEPTH)
    ) u_tok_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tok_push),
        .din   (tok_in),
        .full  (tok_full),
        .pop   (tok_pop),
        .dout  (tok_out),
        .empty (tok_empty)
    );

    assign full = tok_full;

    srlp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok_out),
        .tok_empty (tok_empty),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    srlp_fifo #(
        .WIDTH($bits(srlp_pkg::result_t)),
        .DEPTH(srlp_pkg::RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign error_code  = res_out.error_code;
    assign year        = res_out.year;
    assign month       = res_out.month;
    assign day         = res_out.day;
    assign hour        = res_out.hour;
    assign minute      = res_out.minute;
    assign temperature = $signed(res_out.temperature);

`ifndef SYNTH
    a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full result queue");

    a_err_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error_code != srlp_pkg::ERR_NONE) |->
        (year == '0 && month == '0 && day == '0 && hour == '0 && minute == '0
         && temperature == '0))
        else $error("failed line carries nonzero fields");

    a_ok_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error_code == srlp_pkg::ERR_NONE) |->
        (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31
         && hour <= 5'd23 && minute <= 6'd59))
        else $error("accepted line has field out of fixed range");
`endif

endmodule

[design/srlp_fifo.sv]
// Small register-based first-in first-out queue.
// No dependencies.
module srlp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[design/srlp_front.sv]
// Front end: counts line length, drops truncated and post-NUL bytes,
// classifies bytes into tokens. Depends on srlp_pkg.
module srlp_front #(
    parameter int LINE_LIMIT = srlp_pkg::LINE_LIMIT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     ch,
    input  logic           line_end,
    output logic           tok_push,
    output srlp_pkg::tok_t tok
);

    localparam int CNT_W = $clog2(LINE_LIMIT + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             term_reg, term_next;
    logic [2:0]       cls;

    always_comb
    begin
        if (ch == srlp_pkg::CH_SP || (ch >= srlp_pkg::CH_TAB && ch <= srlp_pkg::CH_CR))
        begin
            cls = srlp_pkg::CLS_SPACE;
        end
        else if (ch == srlp_pkg::CH_PLUS)
        begin
            cls = srlp_pkg::CLS_PLUS;
        end
        else if (ch == srlp_pkg::CH_MINUS)
        begin
            cls = srlp_pkg::CLS_MINUS;
        end
        else if (ch >= srlp_pkg::CH_ZERO && ch <= srlp_pkg::CH_NINE)
        begin
            cls = srlp_pkg::CLS_DIGIT;
        end
        else if (ch == srlp_pkg::CH_SEMI)
        begin
            cls = srlp_pkg::CLS_SEMI;
        end
        else
        begin
            cls = srlp_pkg::CLS_OTHER;
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        term_next    = term_reg;
        tok_push     = 1'b0;
        tok.is_end   = line_end;
        tok.too_long = (count_reg >= CNT_W'(LINE_LIMIT));
        tok.cls      = cls;
        tok.digit    = ch[3:0];
        if (accept)
        begin
            if (line_end)
            begin
                tok_push   = 1'b1;
                count_next = '0;
                term_next  = 1'b0;
            end
            else if (!term_reg)
            begin
                if (ch == srlp_pkg::CH_NUL)
                begin
                    term_next = 1'b1;
                end
                else
                begin
                    tok_push = (count_reg < CNT_W'(LINE_LIMIT - 2));
                    if (count_reg < CNT_W'(LINE_LIMIT))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            term_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            term_reg  <= term_next;
        end
    end

endmodule

[design/srlp_back.sv]
// Back end: column scanner, range checks, field store and result build.
// Holds the configuration registers. Depends on srlp_pkg.
module srlp_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  srlp_pkg::tok_t                  tok,
    input  logic                            tok_empty,
    output logic                            tok_pop,
    input  logic                            res_full,
    output logic                            res_push,
    output srlp_pkg::result_t               res,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [srlp_pkg::YEAR_W-1:0]     cfg_data
);

    localparam logic [1:0] PH_WS     = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    localparam int VW = srlp_pkg::VAL_W;
    localparam int AW = srlp_pkg::ACC_W;

    logic [srlp_pkg::YEAR_W-1:0] year_min_reg, year_max_reg;
    logic [srlp_pkg::TEMP_W-1:0] temp_min_reg, temp_max_reg;

    logic [2:0]    col_reg, col_next;
    logic [1:0]    phase_reg, phase_next;
    logic          neg_reg, neg_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [2:0]    fe_reg, fe_next;
    logic [srlp_pkg::YEAR_W-1:0] store_reg [srlp_pkg::NUM_COLS];
    logic [srlp_pkg::YEAR_W-1:0] store_next [srlp_pkg::NUM_COLS];

    logic                 is_digit, is_semi, do_fin, to_ws, active;
    logic [AW+3:0]        acc_mul;
    logic signed [VW-1:0] fin_val, lo, hi;
    logic                 fin_ok;
    logic [2:0]           err;

    assign is_digit = (tok.cls == srlp_pkg::CLS_DIGIT);
    assign is_semi  = (tok.cls == srlp_pkg::CLS_SEMI);
    assign tok_pop  = !tok_empty && (!tok.is_end || !res_full);
    assign active   = (fe_reg == srlp_pkg::ERR_NONE) && (col_reg < 3'(srlp_pkg::NUM_COLS));
    assign acc_mul  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                      + {{AW{1'b0}}, tok.digit};

    always_comb
    begin
        fin_val = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
        unique case (col_reg)
            3'd0:
            begin
                lo = $signed(VW'(year_min_reg));
                hi = $signed(VW'(year_max_reg));
            end
            3'd1:
            begin
                lo = VW'(srlp_pkg::MONTH_LO);
                hi = VW'(srlp_pkg::MONTH_HI);
            end
            3'd2:
            begin
                lo = VW'(srlp_pkg::DAY_LO);
                hi = VW'(srlp_pkg::DAY_HI);
            end
            3'd3:
            begin
                lo = VW'(srlp_pkg::HOUR_LO);
                hi = VW'(srlp_pkg::HOUR_HI);
            end
            3'd4:
            begin
                lo = VW'(srlp_pkg::MIN_LO);
                hi = VW'(srlp_pkg::MIN_HI);
            end
            default:
            begin
                lo = {{(VW-8){temp_min_reg[7]}}, temp_min_reg};
                hi = {{(VW-8){temp_max_reg[7]}}, temp_max_reg};
            end
        endcase
        fin_ok = (fin_val >= lo) && (fin_val <= hi);
    end

    always_comb
    begin
        col_next   = col_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        fe_next    = fe_reg;
        store_next = store_reg;
        do_fin     = 1'b0;
        to_ws      = 1'b0;
        res_push   = 1'b0;
        err        = srlp_pkg::ERR_NONE;
        res        = '0;

        if (tok_pop && active)
        begin
            if (tok.is_end)
            begin
                do_fin = (phase_reg == PH_DIGITS);
            end
            else
            begin
                unique case (phase_reg)
                    PH_WS:
                    begin
                        if (tok.cls == srlp_pkg::CLS_PLUS || tok.cls == srlp_pkg::CLS_MINUS)
                        begin
                            neg_next   = (tok.cls == srlp_pkg::CLS_MINUS);
                            phase_next = PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            acc_next   = AW'(tok.digit);
                            phase_next = PH_DIGITS;
                        end
                        else if (tok.cls != srlp_pkg::CLS_SPACE)
                        begin
                            fe_next = col_reg + 3'd1;
                        end
                    end
                    PH_SIGN:
                    begin
                        if (is_digit)
                        begin
                            acc_next   = AW'(tok.digit);
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            fe_next = col_reg + 3'd1;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            acc_next = (acc_mul[AW+3:AW] != '0) ? '1 : acc_mul[AW-1:0];
                        end
                        else
                        begin
                            do_fin = 1'b1;
                            to_ws  = is_semi;
                        end
                    end
                    default:
                    begin
                        if (is_semi)
                        begin
                            phase_next = PH_WS;
                        end
                    end
                endcase
            end
        end

        if (do_fin)
        begin
            if (!fin_ok)
            begin
                fe_next = col_reg + 3'd1;
            end
            else
            begin
                store_next[col_reg] = fin_val[srlp_pkg::YEAR_W-1:0];
            end
            col_next   = col_reg + 3'd1;
            phase_next = to_ws ? PH_WS : PH_SKIP;
            neg_next   = 1'b0;
            acc_next   = '0;
        end

        if (tok_pop && tok.is_end)
        begin
            res_push = 1'b1;
            err      = fe_next;
            if (fe_next == srlp_pkg::ERR_NONE && col_next < 3'(srlp_pkg::NUM_COLS))
            begin
                err = col_next + 3'd1;
            end
            if (tok.too_long)
            begin
                err = srlp_pkg::ERR_LONG;
            end
            res.error_code = err;
            if (err == srlp_pkg::ERR_NONE)
            begin
                res.year        = store_next[0];
                res.month       = store_next[1][srlp_pkg::MONTH_W-1:0];
                res.day         = store_next[2][srlp_pkg::DAY_W-1:0];
                res.hour        = store_next[3][srlp_pkg::HOUR_W-1:0];
                res.minute      = store_next[4][srlp_pkg::MIN_W-1:0];
                res.temperature = store_next[5][srlp_pkg::TEMP_W-1:0];
            end
            col_next   = '0;
            phase_next = PH_WS;
            neg_next   = 1'b0;
            acc_next   = '0;
            fe_next    = srlp_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            phase_reg <= PH_WS;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            fe_reg    <= srlp_pkg::ERR_NONE;
        end
        else
        begin
            col_reg   <= col_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            fe_reg    <= fe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_min_reg <= srlp_pkg::YEAR_MIN_RST;
            year_max_reg <= srlp_pkg::YEAR_MAX_RST;
            temp_min_reg <= srlp_pkg::TEMP_MIN_RST;
            temp_max_reg <= srlp_pkg::TEMP_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srlp_pkg::REG_YEAR_MIN: year_min_reg <= cfg_data;
                srlp_pkg::REG_YEAR_MAX: year_max_reg <= cfg_data;
                srlp_pkg::REG_TEMP_MIN: temp_min_reg <= cfg_data[srlp_pkg::TEMP_W-1:0];
                default:                temp_max_reg <= cfg_data[srlp_pkg::TEMP_W-1:0];
            endcase
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Testbench for sensor_record_line_parser: text lines in, parsed records out.
// Checks every result against a built-in line-parsing predictor.
// Depends on srlp_pkg and the sensor_record_line_parser RTL.
module testbench;
    import srlp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LIM = LINE_LIMIT_DEF;

    typedef enum logic [1:0] {SCAN_WS, SCAN_SIGN, SCAN_DIGITS, SCAN_SKIP} scan_st_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       le;
    } text_item_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic [7:0]          ch = 8'd0;
    logic                line_end = 1'b0;
    logic                pop = 1'b0;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = REG_YEAR_MIN;
    logic [YEAR_W-1:0]   cfg_data = '0;
    logic                full;
    logic                empty;
    logic [2:0]          error_code;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MIN_W-1:0]    minute;
    logic signed [TEMP_W-1:0] temperature;

    sensor_record_line_parser uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .ch          (ch),
        .line_end    (line_end),
        .empty       (empty),
        .pop         (pop),
        .error_code  (error_code),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .temperature (temperature),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    // stimulus and expectation stores
    text_item_t  item_q[$];
    logic [7:0]  line_buf[$];
    result_t     parsed_q[$];
    int          items_queued = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          in_taken = 1'b0;
    bit          send_idle_on = 1'b1;
    bit          recv_stall_on = 1'b1;
    int          gap_left = 0;
    int          burst_left = 0;
    int          stall_left = 0;

    // predictor bounds
    int yr_lo = 1900;
    int yr_hi = 2100;
    int t_lo = -99;
    int t_hi = 99;

    // predictor line state
    int       col_done = 0;
    scan_st_t scan_st = SCAN_WS;
    bit       neg = 1'b0;
    int       accum = 0;
    int       n_chars = 0;
    int       fail_col = 0;
    int       vals[NUM_COLS] = '{default: 0};
    bit       stopped = 1'b0;

    function automatic void col_bounds(input int col, output int lo, output int hi);
        case (col)
            0: begin lo = yr_lo; hi = yr_hi; end
            1: begin lo = MONTH_LO; hi = MONTH_HI; end
            2: begin lo = DAY_LO; hi = DAY_HI; end
            3: begin lo = HOUR_LO; hi = HOUR_HI; end
            4: begin lo = MIN_LO; hi = MIN_HI; end
            default: begin lo = t_lo; hi = t_hi; end
        endcase
    endfunction

    function automatic void close_number();
        int v, lo, hi;
        v = neg ? -accum : accum;
        col_bounds(col_done, lo, hi);
        if (v < lo || v > hi)
            fail_col = col_done + 1;
        else
            vals[col_done] = v;
        col_done++;
        scan_st = SCAN_SKIP;
        neg = 1'b0;
        accum = 0;
    endfunction

    function automatic void line_step(input logic [7:0] c, input logic le);
        result_t r;
        bit      is_digit;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        if (!le)
        begin
            if (stopped)
                return;
            if (c == CH_NUL)
            begin
                stopped = 1'b1;
                return;
            end
            if (n_chars < LIM - 2 && fail_col == 0 && col_done < NUM_COLS)
            begin
                case (scan_st)
                    SCAN_WS:
                    begin
                        if (c == CH_SP || (c >= CH_TAB && c <= CH_CR))
                            ;
                        else if (c == CH_PLUS || c == CH_MINUS)
                        begin
                            neg = (c == CH_MINUS);
                            scan_st = SCAN_SIGN;
                        end
                        else if (is_digit)
                        begin
                            accum = c - CH_ZERO;
                            scan_st = SCAN_DIGITS;
                        end
                        else
                            fail_col = col_done + 1;
                    end
                    SCAN_SIGN:
                    begin
                        if (is_digit)
                        begin
                            accum = c - CH_ZERO;
                            scan_st = SCAN_DIGITS;
                        end
                        else
                            fail_col = col_done + 1;
                    end
                    SCAN_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            accum = accum * 10 + (c - CH_ZERO);
                            if (accum > 65535)
                                accum = 65535;
                        end
                        else
                        begin
                            close_number();
                            if (c == CH_SEMI)
                                scan_st = SCAN_WS;
                        end
                    end
                    default:
                    begin
                        if (c == CH_SEMI)
                            scan_st = SCAN_WS;
                    end
                endcase
            end
            if (n_chars < LIM)
                n_chars++;
            return;
        end

        if (fail_col == 0 && col_done < NUM_COLS && scan_st == SCAN_DIGITS)
            close_number();
        if (fail_col == 0 && col_done < NUM_COLS)
            fail_col = col_done + 1;
        r = '0;
        r.error_code = (n_chars >= LIM) ? ERR_LONG : 3'(fail_col);
        if (r.error_code == ERR_NONE)
        begin
            r.year        = vals[0][YEAR_W-1:0];
            r.month       = vals[1][MONTH_W-1:0];
            r.day         = vals[2][DAY_W-1:0];
            r.hour        = vals[3][HOUR_W-1:0];
            r.minute      = vals[4][MIN_W-1:0];
            r.temperature = vals[5][TEMP_W-1:0];
        end
        parsed_q.push_back(r);
        col_done = 0;
        scan_st = SCAN_WS;
        neg = 1'b0;
        accum = 0;
        n_chars = 0;
        fail_col = 0;
        vals = '{default: 0};
        stopped = 1'b0;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40)
            $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // line construction
    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void end_line();
        text_item_t entry;
        foreach (line_buf[i])
        begin
            entry.ch = line_buf[i];
            entry.le = 1'b0;
            item_q.push_back(entry);
        end
        entry.ch = 8'($urandom);
        entry.le = 1'b1;
        item_q.push_back(entry);
        items_queued += line_buf.size() + 1;
        line_buf.delete();
    endfunction

    function automatic logic [7:0] space_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SP : CH_TAB + 8'(k);
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        return (b == CH_SEMI) ? CH_SP : b;
    endfunction

    function automatic void gen_record(input bit pad_long);
        int kind, lo, hi, a, b, v, pick, stop_col;
        kind = $urandom_range(0, 99);
        if (kind >= 3 && kind < 10)
        begin
            repeat ($urandom_range(0, 24))
                line_buf.push_back(8'($urandom));
            end_line();
            return;
        end
        if (pad_long || kind < 3)
            repeat ($urandom_range(230, 262))
                line_buf.push_back(space_char());
        stop_col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : NUM_COLS;
        for (int col = 0; col < NUM_COLS; col++)
        begin
            if (col == stop_col)
                break;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    line_buf.push_back(space_char());
            col_bounds(col, lo, hi);
            a = (lo < hi) ? lo : hi;
            b = (lo < hi) ? hi : lo;
            pick = $urandom_range(0, 99);
            if (pick < 80)
                v = a + int'($urandom_range(0, b - a));
            else
                v = $urandom_range(0, 1) ? lo - 1 : hi + 1;
            if (pick < 88)
            begin
                if (v < 0 || (v == 0 && $urandom_range(0, 5) == 0))
                    line_buf.push_back(CH_MINUS);
                else if ($urandom_range(0, 7) == 0)
                    line_buf.push_back(CH_PLUS);
                if ($urandom_range(0, 9) == 0)
                    add_text("00");
                add_text($sformatf("%0d", (v < 0) ? -v : v));
            end
            else if (pick < 93)
            begin
                if ($urandom_range(0, 1))
                    line_buf.push_back(CH_MINUS);
                repeat ($urandom_range(5, 10))
                    line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            else if (pick < 97)
                line_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    line_buf.push_back(junk_char());
            if (col < NUM_COLS - 1)
                line_buf.push_back(CH_SEMI);
            else if ($urandom_range(0, 5) == 0)
                add_text($sformatf(";%0d;x", $urandom_range(0, 99)));
        end
        if ($urandom_range(0, 29) == 0)
            line_buf.insert($urandom_range(0, line_buf.size()), CH_NUL);
        end_line();
    endfunction

    function automatic void fill_random(input int n);
        int target;
        target = items_queued + n;
        while (items_queued < target)
            gen_record(1'b0);
    endfunction

    // push is stable at the rising edge, so the idle check cannot race the driver
    task automatic drain();
        do
            @(posedge clk);
        while (item_q.size() != 0 || push || parsed_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_bounds(input int ylo, input int yhi, input int tlo, input int thi);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_YEAR_MIN;
        cfg_data <= YEAR_W'(ylo);
        @(negedge clk);
        cfg_index <= REG_YEAR_MAX;
        cfg_data <= YEAR_W'(yhi);
        @(negedge clk);
        cfg_index <= REG_TEMP_MIN;
        cfg_data <= {6'($urandom), 8'(tlo)};
        @(negedge clk);
        cfg_index <= REG_TEMP_MAX;
        cfg_data <= {6'($urandom), 8'(thi)};
        @(negedge clk);
        cfg_we <= 1'b0;
        yr_lo = ylo;
        yr_hi = yhi;
        t_lo = tlo;
        t_hi = thi;
    endtask

    // sender: bursts with random gaps while send_idle_on is set
    always @(negedge clk)
    begin : drive
        text_item_t nxt;
        if (!push || in_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (item_q.size() != 0)
            begin
                nxt = item_q.pop_front();
                push <= 1'b1;
                ch <= nxt.ch;
                line_end <= nxt.le;
                if (burst_left != 0)
                    burst_left--;
                else if (send_idle_on)
                begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = $urandom_range(1, 6);
                end
            end
            else
                push <= 1'b0;
        end
    end

    // receiver: short stalls with an occasional long one while recv_stall_on is set
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            if (recv_stall_on && $urandom_range(0, 5) == 0)
                stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 4);
        end
    end

    always @(posedge clk)
    begin : watch
        result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (parsed_q.size() == 0)
                    flag_mismatch("unexpected result, error_code", error_code, 0);
                else
                begin
                    want = parsed_q.pop_front();
                    if (error_code !== want.error_code)
                        flag_mismatch("error_code", error_code, want.error_code);
                    if (year !== want.year)
                        flag_mismatch("year", year, want.year);
                    if (month !== want.month)
                        flag_mismatch("month", month, want.month);
                    if (day !== want.day)
                        flag_mismatch("day", day, want.day);
                    if (hour !== want.hour)
                        flag_mismatch("hour", hour, want.hour);
                    if (minute !== want.minute)
                        flag_mismatch("minute", minute, want.minute);
                    if (temperature !== want.temperature)
                        flag_mismatch("temperature", temperature,
                                      $signed(want.temperature));
                end
            end
            in_taken = push && !full;
            if (in_taken)
                line_step(ch, line_end);
        end
        else
            in_taken = 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_text("2024;6;15;12;30;25");
        end_line();
        add_text("1900;1;1;0;0;-99");
        end_line();
        add_text("2100;12;31;\n23;59;99");
        end_line();
        add_text(" \t+2000 ;\01307;\01431x;\01523;-0;+0");
        end_line();
        add_text("1899;1;1;0;0;0");
        end_line();
        add_text("2000;1;1;0;0;-100");
        end_line();
        add_text("2000;1;1");
        end_line();
        end_line();
        add_text("99999999;1;1;0;0;0");
        end_line();
        add_text("2000;1");
        line_buf.push_back(CH_NUL);
        add_text(";1;0;0;0");
        end_line();
        add_text("+;1;1;0;0;0");
        end_line();
        add_text("2001;2;3;4;5;6 tail;7;x\377");
        end_line();
        gen_record(1'b1);
        fill_random(120);

        set_bounds(0, 9999, -128, 127);
        send_idle_on = 1'b0;
        fill_random(150);
        drain();
        send_idle_on = 1'b1;
        fill_random(150);

        set_bounds(9999, 0, 127, -128);
        recv_stall_on = 1'b0;
        fill_random(90);

        recv_stall_on = 1'b1;
        set_bounds($urandom_range(1800, 2000), $urandom_range(2000, 2300),
                   -int'($urandom_range(0, 128)), $urandom_range(0, 127));
        fill_random(150);

        set_bounds(2000, 2000, 0, 0);
        fill_random(80);

        drain();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[filelist.f]
design/srlp_pkg.sv
design/srlp_fifo.sv
design/srlp_front.sv
design/srlp_back.sv
design/sensor_record_line_parser.sv
dv/testbench.sv
